// ===== rtl/ilp_pkg.sv =====
// Shared constants and character classification helpers for the integer literal parser.
`default_nettype none

package ilp_pkg;

    localparam int CH_W    = 8;
    localparam int BASE_W  = 6;
    localparam int VALUE_W = 64;
    localparam int DIGIT_W = 6;

    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [CH_W-1:0] CH_UNDER = 8'h5F;  // '_'
    localparam logic [CH_W-1:0] CH_QUOTE = 8'h27;  // '\''
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CH_W-1:0] CH_LO_B  = 8'h62;
    localparam logic [CH_W-1:0] CH_UP_B  = 8'h42;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    // Larger than any legal base, so a non-digit never passes a digit test.
    localparam logic [DIGIT_W-1:0] NOT_DIGIT = 6'd63;

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CH_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NOT_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = DIGIT_W'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = DIGIT_W'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = DIGIT_W'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

    function automatic logic is_sep(input logic [CH_W-1:0] c);
        return (c == CH_UNDER) || (c == CH_QUOTE);
    endfunction

    function automatic logic is_ws(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_literal_parser_core.sv =====
// Top level of the integer literal parser: per-character state update and result register.
`default_nettype none

// Converts a literal, streamed one character per word, into a signed 64-bit value.
// Each input word is processed as it is accepted: the digit multiply-accumulate
// (one 64 x 6 bit multiply plus an add and range compare) sits between the literal
// state registers and the result register, so one word can be accepted every clock while s_tready is high.
// A result is registered in the cycle after the word marked tlast is accepted and waits in the output
// register; s_tready is low only while that register is full and not being taken.
// base_mode (cfg_wr_data) is sampled on the first character of each literal:
// 0 selects automatic prefix detection, 2 to 36 select an explicit base.
module integer_literal_parser_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ilp_pkg::BASE_W-1:0]   cfg_wr_data,   // base_mode
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [ilp_pkg::CH_W-1:0]     s_tdata,       // [7:0] ch
    input  wire logic [0:0]                   s_tuser,       // [0] has_char
    input  wire logic                         s_tlast,       // last
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    output      logic [ilp_pkg::VALUE_W-1:0]  m_tdata,       // [63:0] value
    output      logic [0:0]                   m_tuser        // [0] ok
);

    typedef enum logic [3:0] {
        PH_START,
        PH_A_BEGIN,
        PH_A_SIGN,
        PH_A_ZERO,
        PH_A_DEC,
        PH_A_HEXP,
        PH_A_HEX,
        PH_A_BINP,
        PH_A_BIN,
        PH_E_WS,
        PH_E_SIGN,
        PH_E_ZERO16,
        PH_E_AFTERX,
        PH_E_DIG,
        PH_E_STOP
    } phase_t;

    localparam int PROD_W = ilp_pkg::VALUE_W + ilp_pkg::BASE_W + 1;

    logic [ilp_pkg::BASE_W-1:0]  base_mode_reg;
    phase_t                      phase_reg, phase_next;
    logic [ilp_pkg::VALUE_W-1:0] magnitude_reg, magnitude_next;
    logic                        negative_reg, negative_next;
    logic [ilp_pkg::BASE_W-1:0]  active_base_reg, active_base_next;
    logic                        digit_seen_reg, digit_seen_next;
    logic                        failed_reg, failed_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [ilp_pkg::VALUE_W-1:0] m_tdata_reg, m_tdata_next;
    logic                        ok_reg, ok_next;

    logic                        in_accept;
    logic [ilp_pkg::CH_W-1:0]    c;
    logic [ilp_pkg::DIGIT_W-1:0] d;
    logic                        sep;

    // Resolved phase and base for the current word, after the start-of-literal step.
    phase_t                      ph;
    logic [ilp_pkg::BASE_W-1:0]  b;
    logic [ilp_pkg::BASE_W-1:0]  mul_base;
    logic [PROD_W-1:0]           mac;
    logic [PROD_W-1:0]           limit;
    logic                        mac_ovf;
    logic                        good;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign c         = s_tdata;
    assign d         = ilp_pkg::digit_value(s_tdata);
    assign sep       = ilp_pkg::is_sep(s_tdata);

    always_comb begin
        ph = phase_reg;
        b  = active_base_reg;
        if (phase_reg == PH_START) begin
            b = base_mode_reg;
            if (base_mode_reg == ilp_pkg::BASE_AUTO) begin
                ph = PH_A_BEGIN;
            end else if (base_mode_reg >= ilp_pkg::BASE_BIN &&
                         base_mode_reg <= ilp_pkg::BASE_MAX) begin
                ph = PH_E_WS;
            end
        end
    end

    // The auto-mode base follows from the phase; explicit mode uses the sampled base.
    always_comb begin
        case (ph) inside
            PH_A_HEXP, PH_A_HEX: mul_base = ilp_pkg::BASE_HEX;
            PH_A_BINP, PH_A_BIN: mul_base = ilp_pkg::BASE_BIN;
            PH_E_WS, PH_E_SIGN, PH_E_ZERO16, PH_E_AFTERX, PH_E_DIG, PH_E_STOP:
                mul_base = b;
            default:             mul_base = ilp_pkg::BASE_DEC;
        endcase
    end

    // magnitude * base + d is kept at full width and compared against the
    // largest magnitude allowed for the current sign.
    assign mac     = PROD_W'(magnitude_reg) * PROD_W'(mul_base) + PROD_W'(d);
    assign limit   = negative_reg ? (PROD_W'(1) << (ilp_pkg::VALUE_W - 1))
                                  : ((PROD_W'(1) << (ilp_pkg::VALUE_W - 1)) - PROD_W'(1));
    assign mac_ovf = mac > limit;

    always_comb begin
        logic do_acc;
        do_acc           = 1'b0;
        phase_next       = phase_reg;
        magnitude_next   = magnitude_reg;
        negative_next    = negative_reg;
        active_base_next = active_base_reg;
        digit_seen_next  = digit_seen_reg;
        failed_next      = failed_reg;

        if (s_tuser[0] && !failed_reg) begin
            phase_next       = ph;
            active_base_next = b;
            if (ph == PH_START) begin
                // Unsupported base: the whole literal is rejected.
                failed_next = 1'b1;
            end else if (b != ilp_pkg::BASE_AUTO && sep) begin
                // Separators are dropped everywhere in explicit mode.
                phase_next = ph;
            end else begin
                unique case (ph)
                    PH_A_BEGIN, PH_A_SIGN: begin
                        if (ph == PH_A_BEGIN && c == ilp_pkg::CH_MINUS) begin
                            negative_next = 1'b1;
                            phase_next    = PH_A_SIGN;
                        end else if (c == ilp_pkg::CH_ZERO) begin
                            digit_seen_next = 1'b1;
                            phase_next      = PH_A_ZERO;
                        end else if (d < ilp_pkg::DIGIT_W'(ilp_pkg::BASE_DEC)) begin
                            do_acc     = 1'b1;
                            phase_next = PH_A_DEC;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_A_ZERO: begin
                        if (c == ilp_pkg::CH_LO_X || c == ilp_pkg::CH_UP_X) begin
                            phase_next = PH_A_HEXP;
                        end else if (c == ilp_pkg::CH_LO_B || c == ilp_pkg::CH_UP_B) begin
                            phase_next = PH_A_BINP;
                        end else if (sep) begin
                            phase_next = PH_A_DEC;
                        end else if (d < ilp_pkg::DIGIT_W'(ilp_pkg::BASE_DEC)) begin
                            do_acc     = 1'b1;
                            phase_next = PH_A_DEC;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_A_DEC: begin
                        if (!sep) begin
                            if (d < ilp_pkg::DIGIT_W'(ilp_pkg::BASE_DEC)) begin
                                do_acc = 1'b1;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                    PH_A_HEXP, PH_A_HEX: begin
                        if (!(ph == PH_A_HEX && sep)) begin
                            if (d < ilp_pkg::DIGIT_W'(ilp_pkg::BASE_HEX)) begin
                                do_acc     = 1'b1;
                                phase_next = PH_A_HEX;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                    PH_A_BINP, PH_A_BIN: begin
                        if (!(ph == PH_A_BIN && sep)) begin
                            if (d < ilp_pkg::DIGIT_W'(ilp_pkg::BASE_BIN)) begin
                                do_acc     = 1'b1;
                                phase_next = PH_A_BIN;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                    PH_E_WS, PH_E_SIGN: begin
                        if (ph == PH_E_WS && ilp_pkg::is_ws(c)) begin
                            phase_next = PH_E_WS;
                        end else if (ph == PH_E_WS &&
                                     (c == ilp_pkg::CH_PLUS || c == ilp_pkg::CH_MINUS)) begin
                            negative_next = (c == ilp_pkg::CH_MINUS);
                            phase_next    = PH_E_SIGN;
                        end else if (b == ilp_pkg::BASE_HEX && c == ilp_pkg::CH_ZERO) begin
                            digit_seen_next = 1'b1;
                            phase_next      = PH_E_ZERO16;
                        end else if (d < b) begin
                            do_acc     = 1'b1;
                            phase_next = PH_E_DIG;
                        end else begin
                            phase_next = PH_E_STOP;
                        end
                    end
                    PH_E_ZERO16: begin
                        if (c == ilp_pkg::CH_LO_X || c == ilp_pkg::CH_UP_X) begin
                            phase_next = PH_E_AFTERX;
                        end else if (d < b) begin
                            do_acc     = 1'b1;
                            phase_next = PH_E_DIG;
                        end else begin
                            phase_next = PH_E_STOP;
                        end
                    end
                    PH_E_AFTERX, PH_E_DIG: begin
                        if (d < b) begin
                            do_acc     = 1'b1;
                            phase_next = PH_E_DIG;
                        end else begin
                            phase_next = PH_E_STOP;
                        end
                    end
                    default: begin
                        phase_next = ph;
                    end
                endcase
            end
        end

        if (do_acc) begin
            digit_seen_next = 1'b1;
            if (mac_ovf) begin
                failed_next = 1'b1;
            end else begin
                magnitude_next = mac[ilp_pkg::VALUE_W-1:0];
            end
        end
    end

    // Result judged on the state after the last word has been applied.
    always_comb begin
        if (phase_next == PH_START || failed_next || !digit_seen_next) begin
            good = 1'b0;
        end else if (active_base_next == ilp_pkg::BASE_AUTO) begin
            good = (phase_next == PH_A_ZERO) || (phase_next == PH_A_DEC) ||
                   (phase_next == PH_A_HEX) || (phase_next == PH_A_BIN);
        end else begin
            good = 1'b1;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ok_next       = ok_reg;
        if (in_accept && s_tlast) begin
            m_tvalid_next = 1'b1;
            ok_next       = good;
            if (!good) begin
                m_tdata_next = '0;
            end else if (negative_next) begin
                m_tdata_next = '0 - magnitude_next;
            end else begin
                m_tdata_next = magnitude_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_mode_reg   <= ilp_pkg::BASE_AUTO;
            phase_reg       <= PH_START;
            magnitude_reg   <= '0;
            negative_reg    <= 1'b0;
            active_base_reg <= '0;
            digit_seen_reg  <= 1'b0;
            failed_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            ok_reg          <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_mode_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                if (s_tlast) begin
                    phase_reg       <= PH_START;
                    magnitude_reg   <= '0;
                    negative_reg    <= 1'b0;
                    active_base_reg <= '0;
                    digit_seen_reg  <= 1'b0;
                    failed_reg      <= 1'b0;
                end else begin
                    phase_reg       <= phase_next;
                    magnitude_reg   <= magnitude_next;
                    negative_reg    <= negative_next;
                    active_base_reg <= active_base_next;
                    digit_seen_reg  <= digit_seen_next;
                    failed_reg      <= failed_next;
                end
            end
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            ok_reg       <= ok_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = ok_reg;

endmodule

`default_nettype wire
